FILE: src/mbp_pkg.sv
package mbp_pkg;

  localparam int STORE_BYTES = 64;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 6;
  localparam int IDX_W       = 6;
  localparam int STAT_W      = 2;
  localparam int FILL_W      = 10;
  localparam int CAP_W       = 7;
  localparam int SPAN_BYTES  = 5;
  localparam int WIN_W       = SPAN_BYTES * 8;
  localparam int CNT_W       = 3;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(STORE_BYTES);

  localparam logic [OP_W-1:0] OP_APPEND_U = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND_S = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_APPEND = 3'd1,
    K_REMOVE = 3'd2,
    K_READ   = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic cnt_clr;
    logic cnt_inc;
    logic app_write;
    logic app_done;
    logic rem_shift;
    logic rem_done;
    logic byte_done;
    logic clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  app_last;
    logic  rem_last;
    logic  out_free;
  } stat_t;

  function automatic logic [VALUE_W-1:0] width_mask(input logic [COUNT_W-1:0] n);
    logic [VALUE_W:0] t;
    t = ({{VALUE_W{1'b0}}, 1'b1} << n) - {{VALUE_W{1'b0}}, 1'b1};
    return t[VALUE_W-1:0];
  endfunction

  function automatic logic [7:0] top_mask(input logic [2:0] o);
    return ~(8'hFF >> o);
  endfunction

endpackage

FILE: src/mbp_ctrl.sv
module mbp_ctrl
  import mbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CALC    = 7'b0000010,
    S_APPEND  = 7'b0000100,
    S_REMOVE  = 7'b0001000,
    S_REM_FIN = 7'b0010000,
    S_BYTE    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        case (stat.kind)
          K_APPEND: state_next = S_APPEND;
          K_REMOVE: begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_REMOVE;
          end
          K_READ:   state_next = S_BYTE;
          K_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FINISH;
          end
          default:  state_next = S_FINISH;
        endcase
      end
      S_APPEND: begin
        cmd.app_write = 1'b1;
        if (stat.app_last) begin
          cmd.app_done = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_REMOVE: begin
        cmd.rem_shift = 1'b1;
        if (stat.rem_last) begin
          state_next = S_REM_FIN;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_REM_FIN: begin
        cmd.rem_done = 1'b1;
        state_next   = S_FINISH;
      end
      S_BYTE: begin
        cmd.byte_done = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/mbp_datapath.sv
module mbp_datapath
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic [COUNT_W-1:0]    in_bit_count,
  input  logic [IDX_W-1:0]      in_byte_sel,
  input  logic                  cap_we,
  input  logic [CAP_W-1:0]      cap_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_W-1:0]     out_status,
  output logic [VALUE_W-1:0]    out_value,
  output logic [FILL_W-1:0]     out_fill,
  output logic                  out_overflow
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  logic [OP_W-1:0]    op_r;
  logic [VALUE_W-1:0] val_r;
  logic [COUNT_W-1:0] n_r;
  logic [IDX_W-1:0]   idx_r;
  logic [FILL_W-1:0]  fill;
  logic               ovf;
  logic [CAP_W-1:0]   cap;
  logic [CNT_W-1:0]   cnt;
  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   acc;
  logic [STAT_W-1:0]  res_status;
  logic [VALUE_W-1:0] res_value;

  logic [VALUE_W-1:0] mask, m1, hi_bits, bits;
  logic               sat;
  logic [WIN_W-1:0]   win_calc;
  logic [CAP_W-1:0]   cap_eff;
  logic [FILL_W-1:0]  cap_bits;
  logic [FILL_W:0]    fill_sum;
  logic [FILL_W-1:0]  start;
  logic [ADDR_W-1:0]  base, addr;
  logic [COUNT_W-1:0] span_bits;
  logic [COUNT_W-1:0] rem_shamt;
  logic [WIN_W-1:0]   acc_sh;
  logic [FILL_W-1:0]  byte_base;
  logic [7:0]         fill_mask, wr_byte;
  kind_t              kind;
  logic [STAT_W-1:0]  calc_status;

  // saturation and alignment
  always_comb begin
    mask    = width_mask(n_r);
    m1      = mask >> 1;
    hi_bits = val_r & ~m1;
    bits    = val_r;
    sat     = 1'b0;
    if (op_r == OP_APPEND_U) begin
      if (val_r > mask) begin
        bits = mask;
        sat  = 1'b1;
      end
    end else if (n_r != COUNT_W'(VALUE_W)) begin
      if (!val_r[VALUE_W-1]) begin
        if (hi_bits != '0) begin
          bits = m1;
          sat  = 1'b1;
        end
      end else if (hi_bits != ~m1) begin
        bits = mask & ~m1;
        sat  = 1'b1;
      end
    end
    win_calc = ({bits & mask, 8'h00} << (COUNT_W'(VALUE_W) - n_r)) >> fill[2:0];
  end

  // decision
  always_comb begin
    cap_eff  = (cap > CAP_W'(STORE_BYTES)) ? CAP_W'(STORE_BYTES) : cap;
    cap_bits = FILL_W'({cap_eff, 3'b000});
    fill_sum = {1'b0, fill} + (FILL_W + 1)'(n_r);
    kind        = K_NONE;
    calc_status = ST_OK;
    case (op_r)
      OP_APPEND_U, OP_APPEND_S: begin
        if (n_r == '0) begin
          calc_status = ST_OK;
        end else if (fill_sum > {1'b0, cap_bits}) begin
          calc_status = ST_REFUSED;
        end else begin
          kind        = K_APPEND;
          calc_status = sat ? ST_SAT : ST_OK;
        end
      end
      OP_REMOVE: begin
        if (FILL_W'(n_r) > fill) begin
          calc_status = ST_REFUSED;
        end else if (n_r != '0) begin
          kind = K_REMOVE;
        end
      end
      OP_READ: begin
        if (int'(idx_r) < STORE_BYTES) begin
          kind = K_READ;
        end else begin
          calc_status = ST_REFUSED;
        end
      end
      OP_CLEAR: kind = K_CLEAR;
      default:  calc_status = ST_REFUSED;
    endcase
  end

  always_comb begin
    start     = fill - FILL_W'(n_r);
    base      = (op_r == OP_REMOVE) ? start[ADDR_W+2:3] : fill[ADDR_W+2:3];
    addr      = (op_r == OP_READ) ? idx_r[ADDR_W-1:0] : base + ADDR_W'(cnt);
    span_bits = COUNT_W'(fill[2:0]) + n_r - COUNT_W'(1);
    rem_shamt = COUNT_W'(WIN_W) - COUNT_W'(start[2:0]) - n_r;
    acc_sh    = acc >> rem_shamt;
    byte_base = FILL_W'({idx_r, 3'b000});
    if (fill >= byte_base + FILL_W'(8)) begin
      fill_mask = 8'hFF;
    end else if (fill <= byte_base) begin
      fill_mask = 8'h00;
    end else begin
      fill_mask = top_mask(fill[2:0]);
    end
    if (cnt == '0) begin
      wr_byte = (rdata & top_mask(fill[2:0])) | win[WIN_W-1 -: 8];
    end else begin
      wr_byte = win[WIN_W-1 -: 8];
    end
  end

  always_comb begin
    stat.kind     = kind;
    stat.app_last = (cnt == span_bits[COUNT_W-1:3]);
    stat.rem_last = (cnt == CNT_W'(SPAN_BYTES));
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (cmd.app_write) begin
      mem[addr] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      ovf       <= 1'b0;
      cap       <= CAP_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cap_we) begin
        cap <= cap_data;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.clear) begin
        fill <= '0;
        ovf  <= 1'b0;
      end else if (cmd.app_done) begin
        fill <= fill + FILL_W'(n_r);
        ovf  <= ovf | (res_status == ST_SAT);
      end else if (cmd.rem_done) begin
        fill <= start;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      val_r <= in_value;
      n_r   <= (in_bit_count > COUNT_W'(VALUE_W)) ? COUNT_W'(VALUE_W) : in_bit_count;
      idx_r <= in_byte_sel;
    end
    if (cmd.calc) begin
      res_status <= calc_status;
      res_value  <= '0;
      win        <= win_calc;
    end else if (cmd.app_write) begin
      win <= win << 8;
    end
    if (cmd.rem_shift) begin
      acc <= {acc[WIN_W-9:0], rdata};
    end
    if (cmd.rem_done) begin
      res_value <= acc_sh[VALUE_W-1:0] & mask;
    end
    if (cmd.byte_done) begin
      res_value <= VALUE_W'(rdata & fill_mask);
    end
    if (cmd.load_out) begin
      out_status   <= res_status;
      out_value    <= res_value;
      out_fill     <= fill;
      out_overflow <= ovf;
    end
  end

endmodule

FILE: src/msb_first_bit_packer.sv
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  tuser operation, tdata value,bit_count,byte_sel
// m_        out        m_tvalid / m_tready  tuser status, tdata value_out,fill_bits,overflow
// cfg_      in         cfg_valid/cfg_ready  cfg_data capacity_bytes
//
// one transaction at a time; all pass idle, calc and finish, read byte adds a byte state,
// append adds write states (one store byte written per cycle, up to five), remove adds
// shift states and a done state (five store bytes read through the single memory port)
// rst synchronous: empty store, no overflow, capacity 64; no clearing pass
// result sits in an output register so a stalled m_ side only holds the
// next transaction in its last cycle
module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // value, bit_count, byte_sel, zero pad
  input  logic [OP_W-1:0]       s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // value_out, fill_bits, overflow_sticky, zero pad
  output logic [STAT_W-1:0]     m_tuser,   // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data
);

  cmd_t               cmd;
  stat_t              stat;
  logic [VALUE_W-1:0] value_out;
  logic [FILL_W-1:0]  fill_bits;
  logic               overflow_sticky;

  assign cfg_ready = 1'b1;

  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (s_tuser),
    .in_value      (s_tdata[VALUE_W-1:0]),
    .in_bit_count  (s_tdata[VALUE_W+COUNT_W-1:VALUE_W]),
    .in_byte_sel   (s_tdata[VALUE_W+COUNT_W+IDX_W-1:VALUE_W+COUNT_W]),
    .cap_we        (cfg_valid & cfg_ready),
    .cap_data      (cfg_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (m_tuser),
    .out_value     (value_out),
    .out_fill      (fill_bits),
    .out_overflow  (overflow_sticky)
  );

  assign m_tdata = {{(OUT_DATA_W-VALUE_W-FILL_W-1){1'b0}}, overflow_sticky, fill_bits, value_out};

endmodule

FILE: src/mbp_checker.sv
module mbp_checker
  import mbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]     m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input never accepted back to back
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_W+FILL_W-1:VALUE_W] <= FILL_W'(STORE_BYTES * 8))
    else $error("fill beyond store");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_REFUSED |-> m_tdata[VALUE_W-1:0] == '0)
    else $error("refused result carries data");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_SAT || m_tuser == ST_REFUSED)
    else $error("bad status code");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: sim/bit_packer_monitor.sv
module bit_packer_monitor
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // value, bit_count, byte_sel, zero pad
  input  logic [OP_W-1:0]       s_tuser,   // operation
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // value_out, fill_bits, overflow_sticky, zero pad
  input  logic [STAT_W-1:0]     m_tuser,   // status
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] value_out;
    logic [FILL_W-1:0]  fill_bits;
    logic               overflow_sticky;
  } packer_result_t;

  logic [7:0]       packed_bytes [STORE_BYTES];
  int               fill_level;
  logic             overflow_seen;
  logic [CAP_W-1:0] capacity;
  packer_result_t   expected_results [$];
  packer_result_t   got;
  packer_result_t   want;

  function automatic packer_result_t pack_transaction(input logic [OP_W-1:0]    op,
                                                      input logic [VALUE_W-1:0] val,
                                                      input logic [COUNT_W-1:0] cnt,
                                                      input logic [IDX_W-1:0]   idx);
    packer_result_t     r;
    int                 n;
    int                 limit;
    int                 pos;
    int                 i;
    logic [VALUE_W:0]   wide;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] bits;
    longint             sv;
    longint             hi;
    longint             lo;
    r.status    = ST_OK;
    r.value_out = '0;
    n     = (cnt > 32) ? 32 : int'(cnt);
    limit = ((capacity > STORE_BYTES) ? STORE_BYTES : int'(capacity)) * 8;
    wide  = (33'd1 << n) - 33'd1;
    mask  = wide[VALUE_W-1:0];
    case (op)
      OP_APPEND_U, OP_APPEND_S: begin
        if (n != 0 && fill_level + n > limit) begin
          r.status = ST_REFUSED;
        end else if (n != 0) begin
          bits = val;
          if (op == OP_APPEND_U) begin
            if (n < 32 && val > mask) begin
              bits     = mask;
              r.status = ST_SAT;
            end
          end else if (n < 32) begin
            sv = longint'(signed'(val));
            hi = (longint'(1) << (n - 1)) - 1;
            lo = -(longint'(1) << (n - 1));
            if (sv > hi) begin
              sv       = hi;
              r.status = ST_SAT;
            end else if (sv < lo) begin
              sv       = lo;
              r.status = ST_SAT;
            end
            bits = sv[VALUE_W-1:0];
          end
          bits = bits & mask;
          for (i = 0; i < n; i++) begin
            pos = fill_level + i;
            packed_bytes[pos / 8][7 - pos % 8] = bits[n - 1 - i];
          end
          fill_level += n;
          if (r.status == ST_SAT) begin
            overflow_seen = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (n > fill_level) begin
          r.status = ST_REFUSED;
        end else begin
          for (i = 0; i < n; i++) begin
            pos = fill_level - n + i;
            r.value_out = {r.value_out[VALUE_W-2:0], packed_bytes[pos / 8][7 - pos % 8]};
            packed_bytes[pos / 8][7 - pos % 8] = 1'b0;
          end
          fill_level -= n;
        end
      end
      OP_READ: begin
        r.value_out = {24'd0, packed_bytes[idx]};
      end
      OP_CLEAR: begin
        foreach (packed_bytes[j]) packed_bytes[j] = '0;
        fill_level    = 0;
        overflow_seen = 1'b0;
      end
      default: begin
        r.status = ST_REFUSED;
      end
    endcase
    r.fill_bits       = fill_level[FILL_W-1:0];
    r.overflow_sticky = overflow_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (packed_bytes[j]) packed_bytes[j] = '0;
      fill_level    = 0;
      overflow_seen = 1'b0;
      capacity      = CAP_RESET;
      mismatches    = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status          = m_tuser;
        got.value_out       = m_tdata[0 +: VALUE_W];
        got.fill_bits       = m_tdata[VALUE_W +: FILL_W];
        got.overflow_sticky = m_tdata[VALUE_W + FILL_W];
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, got.value_out);
            mismatches++;
          end
          if (got.fill_bits !== want.fill_bits) begin
            $error("fill_bits: expected %0d, got %0d", want.fill_bits, got.fill_bits);
            mismatches++;
          end
          if (got.overflow_sticky !== want.overflow_sticky) begin
            $error("overflow_sticky: expected %0d, got %0d",
                   want.overflow_sticky, got.overflow_sticky);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(pack_transaction(s_tuser, s_tdata[0 +: VALUE_W],
                                                    s_tdata[VALUE_W +: COUNT_W],
                                                    s_tdata[VALUE_W + COUNT_W +: IDX_W]));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam int              SEGMENTS       = 9;
  localparam int              SEGMENT_ITEMS  = 160;
  localparam int              CAP_PLAN [SEGMENTS] = '{127, 1, 0, 5, 64, 2, 100, 17, 64};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // value, bit_count, byte_sel, zero pad
  logic [OP_W-1:0]       s_tuser   = '0;   // operation
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // value_out, fill_bits, overflow_sticky, zero pad
  logic [STAT_W-1:0]     m_tuser;          // status
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data  = CAP_RESET;
  int                    mismatches;
  int                    outstanding;
  int                    send_idle = 24;
  int                    recv_idle = 87;
  int                    cur_cap   = 64;

  always #1 clk = ~clk;

  msb_first_bit_packer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bit_packer_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(input logic [OP_W-1:0]    op,
                           input logic [VALUE_W-1:0] val,
                           input logic [COUNT_W-1:0] cnt,
                           input logic [IDX_W-1:0]   idx);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W - VALUE_W - COUNT_W - IDX_W){1'b0}}, idx, cnt, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_item();
    int                 pick;
    int                 lim;
    int                 k;
    int                 bytes;
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] cnt;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] val;
    logic [VALUE_W:0]   wide;
    bytes = (cur_cap > STORE_BYTES) ? STORE_BYTES : cur_cap;
    lim   = (bytes == 0 || bytes * 8 > 32) ? 32 : bytes * 8;
    pick  = $urandom_range(99);
    if (pick < 28) begin
      op = OP_APPEND_U;
    end else if (pick < 54) begin
      op = OP_APPEND_S;
    end else if (pick < 76) begin
      op = OP_REMOVE;
    end else if (pick < 92) begin
      op = OP_READ;
    end else if (pick < 95) begin
      op = OP_CLEAR;
    end else begin
      op = OP_SPARE_FIRST + OP_W'($urandom_range(2));
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      cnt = $urandom_range(1) ? '0 : COUNT_W'($urandom_range(63, 33));
    end else if (pick == 1) begin
      cnt = COUNT_W'($urandom_range(32, 1));
    end else begin
      cnt = COUNT_W'($urandom_range(lim, 1));
    end
    k    = (cnt > 32) ? 32 : int'(cnt);
    wide = (33'd1 << k) - 33'd1;
    val  = $urandom();
    if ($urandom_range(1)) begin
      val = val & wide[VALUE_W-1:0];
      if ($urandom_range(1)) begin
        val = ~val;
      end
    end
    if ($urandom_range(1) && bytes != 0) begin
      idx = IDX_W'($urandom_range(bytes - 1));
    end else begin
      idx = IDX_W'($urandom_range(63));
    end
    send_item(op, val, cnt, idx);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    cfg_valid <= 1'b1;
    cfg_data  <= CAP_W'(cap);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_cap = cap;
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty read, width extremes, saturation and clamping, removes, bad codes, clear
    send_item(OP_READ,     32'h0,         6'd0,  6'd0);
    send_item(OP_APPEND_U, 32'hFFFF_FFFF, 6'd32, 6'd0);
    send_item(OP_APPEND_S, 32'h8000_0000, 6'd32, 6'd63);
    send_item(OP_APPEND_U, 32'd5,         6'd3,  6'd0);
    send_item(OP_APPEND_U, 32'd9,         6'd3,  6'd0);
    send_item(OP_APPEND_S, 32'd7,         6'd4,  6'd0);
    send_item(OP_APPEND_S, 32'd8,         6'd4,  6'd0);
    send_item(OP_APPEND_S, 32'hFFFF_FFF7, 6'd4,  6'd0);
    send_item(OP_APPEND_S, 32'hFFFF_FFFF, 6'd1,  6'd0);
    send_item(OP_APPEND_S, 32'd1,         6'd1,  6'd0);
    send_item(OP_APPEND_U, 32'hDEAD_BEEF, 6'd0,  6'd0);
    send_item(OP_APPEND_U, 32'h1234_5678, 6'd63, 6'd0);
    send_item(OP_REMOVE,   32'h0,         6'd0,  6'd0);
    send_item(OP_REMOVE,   32'h0,         6'd40, 6'd0);
    send_item(OP_REMOVE,   32'h0,         6'd7,  6'd0);
    send_item(OP_READ,     32'h0,         6'd0,  6'd1);
    send_item(OP_READ,     32'h0,         6'd0,  6'd63);
    send_item(OP_SPARE_FIRST,             32'hFFFF_FFFF, 6'd8, 6'd0);
    send_item(OP_SPARE_FIRST + OP_W'(1),  32'h0,         6'd8, 6'd0);
    send_item(OP_SPARE_FIRST + OP_W'(2),  32'h0,         6'd8, 6'd0);
    send_item(OP_CLEAR,    32'h0,         6'd0,  6'd0);
    send_item(OP_REMOVE,   32'h0,         6'd1,  6'd0);
    send_item(OP_READ,     32'h0,         6'd0,  6'd0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg / 3)
        0: begin
          send_idle = 24;
          recv_idle = 87;
        end
        1: begin
          send_idle = 87;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_capacity(CAP_PLAN[seg]);
      repeat (SEGMENT_ITEMS) send_random_item();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: msb_first_bit_packer.f
src/mbp_pkg.sv
src/mbp_ctrl.sv
src/mbp_datapath.sv
src/msb_first_bit_packer.sv
src/mbp_checker.sv
sim/bit_packer_monitor.sv
sim/tb.sv
